[sv/bulk_image_block_splitter_macros.svh]
// Assertion macros used by the splitter RTL (bis_queue).
// Define ASSERT_OFF to compile the checks out.
`ifndef BULK_IMAGE_BLOCK_SPLITTER_MACROS_SVH
`define BULK_IMAGE_BLOCK_SPLITTER_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every rising edge outside reset.
`define BIS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The condition must never be true at a rising edge outside reset.
`define BIS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BIS_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[sv/bis_pkg.sv]
`default_nettype none

package bis_pkg;

	// Width of the image position counter and of the offset state.
	localparam int OFFSET_BITS = 24;
	// Position arithmetic carries one extra bit so that p + 1 and start + 8 never wrap.
	localparam int POS_W = OFFSET_BITS + 1;
	// Widths of the reported fields.
	localparam int FIELD_W = 24;
	localparam int BANK_W = 8;

	// Block marker bytes, in stream order.
	localparam logic [7:0] MARK0 = 8'hF0;
	localparam logic [7:0] MARK1 = 8'h41;
	localparam logic [7:0] MARK2 = 8'h6C;
	localparam logic [7:0] MARK3 = 8'h02;
	// Distance from the marker start to the bank byte.
	localparam int BANK_DISTANCE = 8;
	// Offset of the marker start back from its last byte.
	localparam int MARK_BACK = 3;

	// Report queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Number of report candidates one byte can raise.
	localparam int NUM_CAND = 5;

	// One block report.
	typedef struct packed {
		logic               done;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] start;
		logic [BANK_W-1:0]  bank;
	} result_t;

	// The reports raised by one byte: r0 always, r1 when two is set.
	typedef struct packed {
		logic    two;
		result_t r1;
		result_t r0;
	} pair_t;

endpackage

`default_nettype wire

[sv/bulk_image_block_splitter.sv]
// A report enters the report queue when its byte is accepted; m_tdata shows the queue head.
// Throughput: one byte per cycle in while the queue has room; one report per cycle out
// while m_tready is high; a byte raising two reports gives two words. A four-entry
// report queue between scanner and output lets the input run on while the output stalls.
// Reset: arst_n clears the scanner state and empties the queue at once.
`default_nettype none

module bulk_image_block_splitter (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire logic         s_tlast,   // final_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [55:0]       m_tdata,   // [7:0] bank_id, [31:8] block_start, [55:32] block_length
	output logic              m_tlast    // image_done
);

	logic            push;
	bis_pkg::pair_t  push_pair;
	bis_pkg::pair_t  head;
	logic            pop;
	logic            empty;
	logic            full;

	// Scanner: marker match, block tracking and report generation.
	bis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.queue_full (full),
		.push       (push),
		.push_pair  (push_pair)
	);

	// Report queue.
	bis_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pair (push_pair),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	// Output side: one report word per handshake.
	bis_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

[sv/bis_front.sv]
`default_nettype none

module bis_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
	input  wire logic                s_tlast,   // final_byte
	input  wire logic                queue_full,
	output logic                     push,
	output bis_pkg::pair_t           push_pair
);

	// Scanner state.
	logic [1:0]                        match_q;
	logic [bis_pkg::OFFSET_BITS-1:0]   pos_q;
	logic                              inside_q;
	logic [bis_pkg::OFFSET_BITS-1:0]   open_start_q;
	logic [bis_pkg::BANK_W-1:0]        open_bank_q;
	logic                              open_seen_q;
	logic                              held_valid_q;
	logic [bis_pkg::OFFSET_BITS-1:0]   held_start_q;

	// Next-state values.
	logic [1:0]                        match_n;
	logic [bis_pkg::OFFSET_BITS-1:0]   pos_n;
	logic                              inside_n;
	logic [bis_pkg::OFFSET_BITS-1:0]   open_start_n;
	logic [bis_pkg::BANK_W-1:0]        open_bank_n;
	logic                              open_seen_n;
	logic                              held_valid_n;
	logic [bis_pkg::OFFSET_BITS-1:0]   held_start_n;

	// Per-byte work signals.
	logic                              accept;
	logic [bis_pkg::POS_W-1:0]         p_ext;
	logic                              bank_hit;
	logic                              held_hit;
	logic                              matched;
	logic [bis_pkg::OFFSET_BITS-1:0]   mark_start;
	logic [bis_pkg::OFFSET_BITS-1:0]   pos_max;

	// Report candidates in the order they are emitted.
	logic [bis_pkg::NUM_CAND-1:0]      cand_v;
	logic [bis_pkg::BANK_W-1:0]        cand_bank  [bis_pkg::NUM_CAND];
	logic [bis_pkg::OFFSET_BITS-1:0]   cand_start [bis_pkg::NUM_CAND];
	logic [bis_pkg::POS_W-1:0]         cand_end   [bis_pkg::NUM_CAND];

	// The first two candidates and the report count.
	logic [bis_pkg::BANK_W-1:0]        sel_bank  [2];
	logic [bis_pkg::OFFSET_BITS-1:0]   sel_start [2];
	logic [bis_pkg::POS_W-1:0]         sel_end   [2];
	logic [2:0]                        n_rep;
	bis_pkg::result_t                  rep [2];

	// A byte is taken whenever the queue has room for its reports.
	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign pos_max  = '1;

	// Classify the byte and work out the next state and the candidates.
	always_comb begin
		p_ext        = {1'b0, pos_q};
		open_bank_n  = open_bank_q;
		open_seen_n  = open_seen_q;
		held_valid_n = held_valid_q;
		held_start_n = held_start_q;
		inside_n     = inside_q;
		open_start_n = open_start_q;
		matched      = 1'b0;
		cand_v       = '0;
		for (int i = 0; i < bis_pkg::NUM_CAND; i++) begin
			cand_bank[i]  = '0;
			cand_start[i] = '0;
			cand_end[i]   = '0;
		end

		// Capture the bank byte of the open block.
		bank_hit = inside_q && !open_seen_q &&
			({1'b0, open_start_q} + bis_pkg::POS_W'(bis_pkg::BANK_DISTANCE) == p_ext);
		if (bank_hit) begin
			open_bank_n = s_tdata;
			open_seen_n = 1'b1;
		end

		// A held block gets its bank byte and is released.
		held_hit = held_valid_q &&
			({1'b0, held_start_q} + bis_pkg::POS_W'(bis_pkg::BANK_DISTANCE) == p_ext);
		cand_v[0]     = held_hit;
		cand_bank[0]  = s_tdata;
		cand_start[0] = held_start_q;
		cand_end[0]   = {1'b0, open_start_q};
		if (held_hit) begin
			held_valid_n = 1'b0;
		end

		// Marker matcher; markers never overlap.
		if (match_q == 2'd3 && s_tdata == bis_pkg::MARK3) begin
			matched = 1'b1;
			match_n = 2'd0;
		end else if (match_q == 2'd2 && s_tdata == bis_pkg::MARK2) begin
			match_n = 2'd3;
		end else if (match_q == 2'd1 && s_tdata == bis_pkg::MARK1) begin
			match_n = 2'd2;
		end else if (s_tdata == bis_pkg::MARK0) begin
			match_n = 2'd1;
		end else begin
			match_n = 2'd0;
		end

		mark_start = (pos_q >= bis_pkg::OFFSET_BITS'(bis_pkg::MARK_BACK)) ?
			pos_q - bis_pkg::OFFSET_BITS'(bis_pkg::MARK_BACK) : '0;

		// A new marker closes the open block and opens another.
		if (matched) begin
			if (inside_q) begin
				if (open_seen_n) begin
					cand_v[1]     = 1'b1;
					cand_bank[1]  = open_bank_n;
					cand_start[1] = open_start_q;
					cand_end[1]   = {1'b0, mark_start};
				end else begin
					// Only one block can wait; an older one goes out with bank 0.
					cand_v[2]     = held_valid_n;
					cand_start[2] = held_start_n;
					cand_end[2]   = {1'b0, open_start_q};
					held_valid_n  = 1'b1;
					held_start_n  = open_start_q;
				end
			end
			inside_n     = 1'b1;
			open_start_n = mark_start;
			open_bank_n  = '0;
			open_seen_n  = 1'b0;
		end

		// End of image flushes the held block and then the open one.
		if (s_tlast) begin
			cand_v[3]     = held_valid_n;
			cand_start[3] = held_start_n;
			cand_end[3]   = {1'b0, open_start_n};
			cand_v[4]     = inside_n;
			cand_bank[4]  = open_seen_n ? open_bank_n : '0;
			cand_start[4] = open_start_n;
			cand_end[4]   = p_ext + bis_pkg::POS_W'(1);
		end

		// The position counter sticks at its top value.
		pos_n = (pos_q != pos_max) ? pos_q + bis_pkg::OFFSET_BITS'(1) : pos_max;
	end

	// Keep the first two candidates; later ones are dropped.
	always_comb begin
		n_rep = '0;
		for (int k = 0; k < 2; k++) begin
			sel_bank[k]  = '0;
			sel_start[k] = '0;
			sel_end[k]   = '0;
		end
		for (int i = 0; i < bis_pkg::NUM_CAND; i++) begin
			if (cand_v[i]) begin
				if (n_rep == 3'd0) begin
					sel_bank[0]  = cand_bank[i];
					sel_start[0] = cand_start[i];
					sel_end[0]   = cand_end[i];
				end else if (n_rep == 3'd1) begin
					sel_bank[1]  = cand_bank[i];
					sel_start[1] = cand_start[i];
					sel_end[1]   = cand_end[i];
				end
				if (n_rep != 3'd2) begin
					n_rep = n_rep + 3'd1;
				end
			end
		end
	end

	// Lengths never go negative; fields are cut to the report width.
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rep[k].bank   = sel_bank[k];
			rep[k].start  = bis_pkg::FIELD_W'(sel_start[k]);
			rep[k].length = (sel_end[k] > {1'b0, sel_start[k]}) ?
				bis_pkg::FIELD_W'(sel_end[k] - {1'b0, sel_start[k]}) : '0;
			rep[k].done   = 1'b0;
		end
		// The last report of the final byte closes the image.
		if (s_tlast) begin
			if (n_rep == 3'd2) begin
				rep[1].done = 1'b1;
			end else begin
				rep[0].done = 1'b1;
			end
		end
		push_pair.r0  = rep[0];
		push_pair.r1  = rep[1];
		push_pair.two = (n_rep == 3'd2);
		push          = accept && (n_rep != 3'd0);
	end

	// State update on every accepted byte; the final byte returns to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q      <= '0;
			pos_q        <= '0;
			inside_q     <= 1'b0;
			open_start_q <= '0;
			open_bank_q  <= '0;
			open_seen_q  <= 1'b0;
			held_valid_q <= 1'b0;
			held_start_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				match_q      <= '0;
				pos_q        <= '0;
				inside_q     <= 1'b0;
				open_start_q <= '0;
				open_bank_q  <= '0;
				open_seen_q  <= 1'b0;
				held_valid_q <= 1'b0;
				held_start_q <= '0;
			end else begin
				match_q      <= match_n;
				pos_q        <= pos_n;
				inside_q     <= inside_n;
				open_start_q <= open_start_n;
				open_bank_q  <= open_bank_n;
				open_seen_q  <= open_seen_n;
				held_valid_q <= held_valid_n;
				held_start_q <= held_start_n;
			end
		end
	end

endmodule

`default_nettype wire

[sv/bis_queue.sv]
`default_nettype none

`include "bulk_image_block_splitter_macros.svh"

module bis_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bis_pkg::pair_t  push_pair,
	input  wire logic            pop,
	output bis_pkg::pair_t       head,
	output logic                 empty,
	output logic                 full
);

	bis_pkg::pair_t                mem_q [bis_pkg::QUEUE_DEPTH];
	logic [bis_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [bis_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [bis_pkg::QCNT_W-1:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == bis_pkg::QCNT_W'(bis_pkg::QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Pointer advance with wrap at the queue depth.
	function automatic logic [bis_pkg::QPTR_W-1:0] next_ptr(
		input logic [bis_pkg::QPTR_W-1:0] ptr
	);
		if (ptr == bis_pkg::QPTR_W'(bis_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + bis_pkg::QPTR_W'(1);
	endfunction

	// Storage holds payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pair;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + bis_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - bis_pkg::QCNT_W'(1);
			end
		end
	end

	`BIS_NEVER(a_push_full, clk, arst_n, push && full, "report pushed into a full queue")
	`BIS_NEVER(a_pop_empty, clk, arst_n, pop && empty, "report popped from an empty queue")
	`BIS_NEVER(a_cnt_range, clk, arst_n, cnt_q > bis_pkg::QCNT_W'(bis_pkg::QUEUE_DEPTH), "queue count out of range")
	`BIS_NEVER(a_ptr_empty, clk, arst_n, empty && (wr_ptr_q != rd_ptr_q), "pointers differ on an empty queue")
	`BIS_ASSERT(a_cnt_up, clk, arst_n, push && !pop |=> cnt_q == $past(cnt_q) + bis_pkg::QCNT_W'(1), "queue count missed a push")

endmodule

`default_nettype wire

[sv/bis_back.sv]
`default_nettype none

module bis_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bis_pkg::pair_t  head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [55:0]          m_tdata,   // [7:0] bank_id, [31:8] block_start, [55:32] block_length
	output logic                 m_tlast    // image_done
);

	// Which report of the head entry is on the bus.
	logic              sel_q;
	logic              take;
	logic              last_slot;
	bis_pkg::result_t  cur;

	assign cur       = sel_q ? head.r1 : head.r0;
	assign m_tvalid  = !empty;
	assign m_tdata   = {cur.length, cur.start, cur.bank};
	assign m_tlast   = cur.done;
	assign take      = m_tvalid && m_tready;
	assign last_slot = sel_q || !head.two;
	assign pop       = take && last_slot;

	// Step through the one or two reports of the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= !last_slot;
		end
	end

endmodule

`default_nettype wire

[sim/block_report_checker.sv]
// Watches both streams of the splitter, predicts the block reports that each
// accepted byte word raises, and compares every accepted report word with the
// oldest prediction.
module block_report_checker
	import bis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // final_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,   // [7:0] bank_id, [31:8] block_start, [55:32] block_length
	input  logic        m_tlast,   // image_done
	output int          mismatches,
	output int          reports_pending
);

	localparam int MAX_REPORTS_PER_BYTE = 2;
	localparam logic [POS_W-1:0] POS_LIMIT = {1'b0, {OFFSET_BITS{1'b1}}};

	// Scanner state of the predictor.
	logic [1:0]       marker_hits;
	logic [POS_W-1:0] next_pos;
	logic             block_open;
	logic [POS_W-1:0] cur_start;
	logic [7:0]       cur_bank;
	logic             cur_bank_known;
	logic             close_waiting;
	logic [POS_W-1:0] waiting_start;

	// Reports predicted but not yet seen on the output.
	result_t reports_due[$];

	result_t got;
	result_t want;
	logic    report_bad;

	task automatic clear_scan();
		marker_hits = '0;
		next_pos = '0;
		block_open = 1'b0;
		cur_start = '0;
		cur_bank = '0;
		cur_bank_known = 1'b0;
		close_waiting = 1'b0;
		waiting_start = '0;
	endtask

	// Queues one report; anything beyond the per-byte limit is lost.
	task automatic queue_report(input logic [7:0] bank, input logic [POS_W-1:0] open_at,
			input logic [POS_W-1:0] close_at, inout int count);
		result_t r;
		logic [POS_W-1:0] span;
		if (count < MAX_REPORTS_PER_BYTE) begin
			span = (close_at > open_at) ? close_at - open_at : '0;
			r.done = 1'b0;
			r.bank = bank;
			r.start = open_at[FIELD_W-1:0];
			r.length = span[FIELD_W-1:0];
			reports_due.insert(reports_due.size(), r);
			count++;
		end
	endtask

	// Advances the scanner by one byte and queues the reports it raises.
	task automatic scan_byte(input logic [7:0] b, input logic fin);
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] mark_start;
		logic             matched;
		int               count;
		p = next_pos;
		matched = 1'b0;
		count = 0;

		// Bank byte of the open block, or of a block closed too early.
		if (block_open && !cur_bank_known && cur_start + BANK_DISTANCE == p) begin
			cur_bank = b;
			cur_bank_known = 1'b1;
		end
		if (close_waiting && waiting_start + BANK_DISTANCE == p) begin
			queue_report(b, waiting_start, cur_start, count);
			close_waiting = 1'b0;
		end

		// Marker matcher; markers never overlap.
		if (marker_hits == 2'd3 && b == MARK3) begin
			matched = 1'b1;
			marker_hits = 2'd0;
		end else if (marker_hits == 2'd2 && b == MARK2) begin
			marker_hits = 2'd3;
		end else if (marker_hits == 2'd1 && b == MARK1) begin
			marker_hits = 2'd2;
		end else if (b == MARK0) begin
			marker_hits = 2'd1;
		end else begin
			marker_hits = 2'd0;
		end

		// A new marker closes the open block and opens the next one.
		if (matched) begin
			mark_start = (p >= MARK_BACK) ? p - POS_W'(MARK_BACK) : '0;
			if (block_open) begin
				if (cur_bank_known) begin
					queue_report(cur_bank, cur_start, mark_start, count);
				end else begin
					if (close_waiting)
						queue_report(8'h00, waiting_start, cur_start, count);
					close_waiting = 1'b1;
					waiting_start = cur_start;
				end
			end
			block_open = 1'b1;
			cur_start = mark_start;
			cur_bank = '0;
			cur_bank_known = 1'b0;
		end

		// End of image flushes everything and starts over.
		if (fin) begin
			if (close_waiting)
				queue_report(8'h00, waiting_start, cur_start, count);
			if (block_open)
				queue_report(cur_bank_known ? cur_bank : 8'h00, cur_start, p + 1'b1, count);
			if (count > 0)
				reports_due[reports_due.size() - 1].done = 1'b1;
			clear_scan();
		end else begin
			next_pos = (p < POS_LIMIT) ? p + 1'b1 : POS_LIMIT;
		end
	endtask

	// The output word is compared before the input word is scanned, since a
	// report never leaves in the cycle its byte is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			reports_due.delete();
			mismatches = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'({m_tlast, m_tdata});
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected report: bank %0h start %0d length %0d done %0b",
						$time, got.bank, got.start, got.length, got.done);
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					report_bad = 1'b0;
					if (got.bank !== want.bank) begin
						$display("%0t: bank_id expected %0h, got %0h", $time, want.bank, got.bank);
						report_bad = 1'b1;
					end
					if (got.start !== want.start) begin
						$display("%0t: block_start expected %0d, got %0d",
							$time, want.start, got.start);
						report_bad = 1'b1;
					end
					if (got.length !== want.length) begin
						$display("%0t: block_length expected %0d, got %0d",
							$time, want.length, got.length);
						report_bad = 1'b1;
					end
					if (got.done !== want.done) begin
						$display("%0t: image_done expected %0b, got %0b", $time, want.done, got.done);
						report_bad = 1'b1;
					end
					if (report_bad)
						mismatches++;
				end
			end
			if (s_tvalid && s_tready)
				scan_byte(s_tdata, s_tlast);
		end
		reports_pending = reports_due.size();
	end

endmodule

[sim/tb.sv]
module tb;
	import bis_pkg::*;

	localparam int RANDOM_BYTES = 800;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;

	int check_errors;
	int reports_pending;

	logic [7:0] image_q[$];
	int         bytes_sent;
	int         image_target;
	int         run_len;
	bit         image_no_idle;
	int         ready_left = 0;
	int         ready_gap;

	bulk_image_block_splitter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	block_report_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.mismatches     (check_errors),
		.reports_pending(reports_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly no pause, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Output back-pressure, with occasional long stretches of full readiness.
	always @(negedge clk) begin
		if (ready_left > 0) begin
			ready_left = ready_left - 1;
		end else if ($urandom_range(0, 19) == 0) begin
			m_tready <= 1'b1;
			ready_left = $urandom_range(100, 300);
		end else begin
			ready_gap = pick_gap();
			m_tready <= (ready_gap == 0);
			ready_left = (ready_gap == 0) ? $urandom_range(0, 6) : ready_gap - 1;
		end
	end

	// Offers one byte word and waits until it is taken.
	task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom_range(0, 255));
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic send_image();
		for (int i = 0; i < image_q.size(); i++)
			send_byte(image_q[i], i == image_q.size() - 1, image_no_idle ? 0 : pick_gap());
		bytes_sent += image_q.size();
	endtask

	// Appends one byte to the image under construction.
	task automatic add_byte(input logic [7:0] b);
		image_q.insert(image_q.size(), b);
	endtask

	task automatic add_marker();
		add_byte(MARK0);
		add_byte(MARK1);
		add_byte(MARK2);
		add_byte(MARK3);
	endtask

	// Random image: markers with random content between them, plus
	// broken markers, repeated first bytes and plain noise.
	task automatic build_image();
		image_q.delete();
		image_target = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
			: $urandom_range(1, 40);
		if ($urandom_range(0, 9) < 8)
			add_marker();
		while (image_q.size() < image_target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: add_marker();
				3, 4, 5: begin
					run_len = $urandom_range(0, 12);
					repeat (run_len)
						add_byte(8'($urandom_range(0, 255)));
				end
				6: begin
					add_byte(MARK0);
					if ($urandom_range(0, 1)) add_byte(MARK1);
					if ($urandom_range(0, 1)) add_byte(MARK2);
					add_byte(8'($urandom_range(0, 255)));
				end
				7: add_byte(MARK0);
				default: add_byte(8'($urandom_range(0, 255)));
			endcase
		end
		while (image_q.size() > image_target)
			void'(image_q.pop_back());
	endtask

	initial begin
		bytes_sent = 0;
		image_no_idle = 1'b0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Leading bytes ignored, marker on the final byte.
		image_q = {8'h00, 8'hFF, MARK0, MARK1, MARK2, MARK3};
		send_image();
		// Back-to-back markers: the first block waits for its bank byte.
		image_q = {MARK0, MARK1, MARK2, MARK3, MARK0, MARK1, MARK2, MARK3,
			8'h11, 8'h22, 8'h33, 8'h44, 8'hFF};
		send_image();
		// No marker at all, so no report.
		image_q = {8'hAA, 8'h55};
		send_image();
		// Restarted match, image ends before the bank byte.
		image_q = {MARK0, MARK0, MARK1, MARK2, MARK3, 8'h00};
		send_image();

		while (bytes_sent < RANDOM_BYTES + 27) begin
			image_no_idle = ($urandom_range(0, 3) == 0);
			build_image();
			send_image();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (reports_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (check_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#(500_000 * 8);
		$display("FAIL");
		$finish;
	end

endmodule
